@@ src/lppd_pkg.sv @@
// ----------------------------------------------------------------------------
// lppd_pkg
// shared types and constants for the length-prefixed packet deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lppd_pkg;

    // header byte positions, in arrival order
    localparam logic [1:0] HDR_SIZE_LO = 2'd0;
    localparam logic [1:0] HDR_SIZE_HI = 2'd1;
    localparam logic [1:0] HDR_TYPE_LO = 2'd2;
    localparam logic [1:0] HDR_TYPE_HI = 2'd3;

    // one result word
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] packet_type;
        logic [15:0] payload_length;
        logic        first_of_packet;
        logic        last_of_packet;
        logic        empty_packet;
    } lppd_result_t;

endpackage

`default_nettype wire

@@ src/lppd_parser.sv @@
// ----------------------------------------------------------------------------
// lppd_parser
// header capture, payload countdown and results; one byte per cycle on accept
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lppd_parser
    import lppd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   rx_byte,
    output lppd_result_t      result,
    output logic              result_valid
);

    logic [1:0]  header_index_reg, header_index_next;
    logic        in_payload_reg, in_payload_next;
    logic [15:0] size_reg, size_next;
    logic [15:0] type_reg, type_next;
    logic [15:0] remaining_reg, remaining_next;

    logic        first;
    logic        last;

    always_comb
    begin
        header_index_next = header_index_reg;
        in_payload_next   = in_payload_reg;
        size_next         = size_reg;
        type_next         = type_reg;
        remaining_next    = remaining_reg;
        result_valid      = 1'b0;
        first             = (remaining_reg == size_reg);
        last              = (remaining_reg <= 16'd1);

        result.payload_byte    = rx_byte;
        result.first_of_packet = first;
        result.last_of_packet  = last;
        result.empty_packet    = 1'b0;

        if (accept)
        begin
            if (in_payload_reg)
            begin
                result_valid = 1'b1;
                if (last)
                begin
                    remaining_next    = 16'd0;
                    in_payload_next   = 1'b0;
                    header_index_next = HDR_SIZE_LO;
                end
                else
                begin
                    remaining_next = remaining_reg - 16'd1;
                end
            end
            else
            begin
                unique case (header_index_reg)
                    HDR_SIZE_LO: size_next = {size_reg[15:8], rx_byte};
                    HDR_SIZE_HI: size_next = {rx_byte, size_reg[7:0]};
                    HDR_TYPE_LO: type_next = {type_reg[15:8], rx_byte};
                    default:     type_next = {rx_byte, type_reg[7:0]};
                endcase

                if (header_index_reg != HDR_TYPE_HI)
                begin
                    header_index_next = header_index_reg + 2'd1;
                end
                else
                begin
                    header_index_next = HDR_SIZE_LO;
                    if (size_reg == 16'd0)
                    begin
                        // zero-length packet: a single flagged word
                        remaining_next         = 16'd0;
                        result_valid           = 1'b1;
                        result.payload_byte    = 8'd0;
                        result.first_of_packet = 1'b1;
                        result.last_of_packet  = 1'b1;
                        result.empty_packet    = 1'b1;
                    end
                    else
                    begin
                        remaining_next  = size_reg;
                        in_payload_next = 1'b1;
                    end
                end
            end
        end

        result.packet_type    = type_next;
        result.payload_length = size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_index_reg <= HDR_SIZE_LO;
            in_payload_reg   <= 1'b0;
            size_reg         <= 16'd0;
            type_reg         <= 16'd0;
            remaining_reg    <= 16'd0;
        end
        else
        begin
            header_index_reg <= header_index_next;
            in_payload_reg   <= in_payload_next;
            size_reg         <= size_next;
            type_reg         <= type_next;
            remaining_reg    <= remaining_next;
        end
    end

endmodule

`default_nettype wire

@@ src/lppd_out_buf.sv @@
// ----------------------------------------------------------------------------
// lppd_out_buf
// output register with a skid stage, so input keeps flowing under stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lppd_out_buf
    import lppd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  lppd_result_t       push_data,
    output logic               full,
    output logic               out_valid,
    input  wire logic          out_stall,
    output lppd_result_t       out_data
);

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    lppd_result_t main_reg, main_next;
    lppd_result_t skid_reg, skid_next;
    logic         take;

    assign take      = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            // no push possible while the skid word is held
            if (take)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!main_valid_reg || take)
        begin
            main_valid_next = push;
            if (push)
            begin
                main_next = push_data;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

@@ src/length_prefixed_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// splits a received byte stream into length-prefixed packets
// ----------------------------------------------------------------------------
// The block takes one byte per cycle whenever in_stall is low. Each
// packet opens with a four-byte header: payload size (16 bits, little-endian)
// then packet type (16 bits, little-endian). Header bytes give no output
// word; each payload byte goes out through the output register, or through
// the skid stage while the output stalls, tagged with the type, the length
// and first/last markers. A header with size zero gives one word with the
// empty, first and last flags set and a zero data byte. The per-byte rate is
// set by the header capture and 16-bit remaining-count update; an output
// register plus a one-word skid stage let input bytes keep flowing while the
// output side stalls, and in_stall rises only once both of those hold words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_packet_deframer
    import lppd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // received byte stream
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    // deframed payload words
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       payload_byte,
    output logic [15:0]      packet_type,
    output logic [15:0]      payload_length,
    output logic             first_of_packet,
    output logic             last_of_packet,
    output logic             empty_packet
);

    logic         accept;
    logic         buf_full;
    logic         res_valid;
    lppd_result_t res;
    lppd_result_t out_word;

    // stall comes straight from a register, no path from out_stall
    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    lppd_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .result       (res),
        .result_valid (res_valid)
    );

    lppd_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_word)
    );

    assign payload_byte    = out_word.payload_byte;
    assign packet_type     = out_word.packet_type;
    assign payload_length  = out_word.payload_length;
    assign first_of_packet = out_word.first_of_packet;
    assign last_of_packet  = out_word.last_of_packet;
    assign empty_packet    = out_word.empty_packet;

endmodule

`default_nettype wire

@@ src/lppd_checker.sv @@
// ----------------------------------------------------------------------------
// lppd_checker
// port-level checks on the deframer output stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lppd_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  payload_byte,
    input  wire logic [15:0] packet_type,
    input  wire logic [15:0] payload_length,
    input  wire logic        first_of_packet,
    input  wire logic        last_of_packet,
    input  wire logic        empty_packet
);

    // a stalled word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_byte)
            && $stable(packet_type) && $stable(first_of_packet))
        else $error("stalled output word changed");

    // an empty packet is a lone word with zero data
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_packet |-> first_of_packet && last_of_packet
            && (payload_byte == 8'd0) && (payload_length == 16'd0))
        else $error("malformed empty packet word");

    // a packet still open cannot be followed at once by a new first word
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_packet |=> !(out_valid && first_of_packet))
        else $error("packet restarted before its last word");

    // header fields stay fixed within a packet
    a_header_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_packet ##1 out_valid |->
            (packet_type == $past(packet_type)) && (payload_length == $past(payload_length)))
        else $error("header fields changed inside a packet");

endmodule

bind length_prefixed_packet_deframer lppd_checker u_lppd_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .payload_byte    (payload_byte),
    .packet_type     (packet_type),
    .payload_length  (payload_length),
    .first_of_packet (first_of_packet),
    .last_of_packet  (last_of_packet),
    .empty_packet    (empty_packet)
);

`default_nettype wire
